/* sv/dsmrc_pkg.sv */
package dsmrc_pkg;

  localparam int FRAME_BYTES   = 16;
  localparam int CHANNEL_SLOTS = 16;

  localparam int FB_AW = $clog2(FRAME_BYTES);
  localparam int FB_PW = $clog2(FRAME_BYTES + 2);
  localparam int CS_AW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;

  localparam int PULSE_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PULSE_W-1:0] PULSE_OFFSET  = 11'd988;
  localparam logic [PULSE_W-1:0] PULSE_DEFAULT = 11'd1500;
  localparam logic [15:0]        GAP_RESET     = 16'd5000;
  localparam logic [4:0]         LIMIT_RESET   = 5'd12;

  // The first word pair starts right after the two-byte header.
  localparam logic [FB_PW-1:0] FIRST_PAIR_HI = FB_PW'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_RES_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CH_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 2'd2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_DEC_HI,
    ST_DEC_LO,
    ST_DEC_WR,
    ST_TBL_RD,
    ST_TBL_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic dec_start;
    logic byte_upd;
    logic fs_re;
    logic hi_cap;
    logic tbl_we;
    logic dec_done;
    logic tbl_re;
    logic cap_read;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic pending;
    logic more_pairs;
    logic out_free;
  } dp_sts_t;

endpackage

/* sv/dsmrc_ram.sv */
module dsmrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/dsmrc_ctrl.sv */
module dsmrc_ctrl
  import dsmrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_command,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_BYTE) begin
            state_nxt = ST_BYTE;
          end else if (sts.pending) begin
            state_nxt = ST_DEC_HI;
          end else begin
            state_nxt = ST_TBL_RD;
          end
        end
      end
      ST_BYTE:     state_nxt = ST_FIN;
      ST_DEC_HI:   state_nxt = ST_DEC_LO;
      ST_DEC_LO:   state_nxt = ST_DEC_WR;
      ST_DEC_WR: begin
        // The next high byte is fetched here, so later pairs skip ST_DEC_HI.
        state_nxt = sts.more_pairs ? ST_DEC_LO : ST_TBL_RD;
      end
      ST_TBL_RD:   state_nxt = ST_TBL_WAIT;
      ST_TBL_WAIT: state_nxt = ST_FIN;
      ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.latch_in  = accept;
        cmd.dec_start = accept;
      end
      ST_BYTE: begin
        cmd.byte_upd = 1'b1;
      end
      ST_DEC_HI: begin
        cmd.fs_re = 1'b1;
      end
      ST_DEC_LO: begin
        cmd.fs_re  = 1'b1;
        cmd.hi_cap = 1'b1;
      end
      ST_DEC_WR: begin
        cmd.tbl_we   = 1'b1;
        cmd.fs_re    = sts.more_pairs;
        cmd.dec_done = !sts.more_pairs;
      end
      ST_TBL_RD: begin
        cmd.tbl_re = 1'b1;
      end
      ST_TBL_WAIT: begin
        cmd.cap_read = 1'b1;
      end
      ST_FIN: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* sv/dsmrc_dp.sv */
module dsmrc_dp
  import dsmrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [7:0]            in_data_byte,
  input  logic [31:0]           in_timestamp_us,
  input  logic [7:0]            in_channel_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PULSE_W-1:0]    out_pulse_us,
  output logic                  out_frame_complete,
  output logic                  out_index_out_of_range
);

  logic             cfg_mode_r;
  logic [4:0]       cfg_limit_r;
  logic [15:0]      cfg_gap_r;

  logic [7:0]       data_r;
  logic [31:0]      ts_r;
  logic [7:0]       idx_r;

  logic [FB_AW-1:0] pos_r, pos_nxt;
  logic [31:0]      last_r, last_nxt;
  logic             pending_r, pending_nxt;
  logic [FB_PW-1:0] ptr_r, ptr_nxt;
  logic [7:0]       hi_r;
  logic [CHANNEL_SLOTS-1:0] tv_r, tv_nxt;

  logic [PULSE_W-1:0] res_pulse_r;
  logic               res_done_r;
  logic               res_oor_r;

  logic               out_valid_r, out_valid_nxt;
  logic [PULSE_W-1:0] out_pulse_r;
  logic               out_done_r;
  logic               out_oor_r;

  logic [31:0]      gap;
  logic             restart;
  logic [FB_AW-1:0] pos_base;
  logic [FB_AW:0]   pos_inc;
  logic             frame_done;

  logic [7:0]         fs_rdata;
  logic [3:0]         dec_id;
  logic [9:0]         dec_base;
  logic [PULSE_W-1:0] dec_value;
  logic               tbl_wen;
  logic [CS_AW-1:0]   tbl_waddr;
  logic [PULSE_W-1:0] tbl_rdata;
  logic               idx_oor;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r  <= 1'b0;
      cfg_limit_r <= LIMIT_RESET;
      cfg_gap_r   <= GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RES_MODE:  cfg_mode_r  <= cfg_wdata[0];
        CFG_CH_LIMIT:  cfg_limit_r <= cfg_wdata[4:0];
        CFG_GAP_LIMIT: cfg_gap_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      data_r <= in_data_byte;
      ts_r   <= in_timestamp_us;
      idx_r  <= in_channel_index;
    end
    if (cmd.hi_cap) begin
      hi_r <= fs_rdata;
    end
  end

  // Byte path: the gap is taken modulo 2^32 against the previous arrival.
  assign gap        = ts_r - last_r;
  assign restart    = gap > {16'd0, cfg_gap_r};
  assign pos_base   = restart ? '0 : pos_r;
  assign pos_inc    = {1'b0, pos_base} + (FB_AW + 1)'(1);
  assign frame_done = (pos_inc == (FB_AW + 1)'(FRAME_BYTES));

  // Word pair decode: both modes reduce to a 10-bit base plus the offset.
  assign dec_id    = cfg_mode_r ? hi_r[5:2] : hi_r[6:3];
  assign dec_base  = cfg_mode_r ? {hi_r[1:0], fs_rdata} : {hi_r[2:0], fs_rdata[7:1]};
  assign dec_value = {1'b0, dec_base} + PULSE_OFFSET;
  assign tbl_wen   = cmd.tbl_we && ({1'b0, dec_id} < cfg_limit_r)
                     && ({1'b0, dec_id} < 5'(CHANNEL_SLOTS));
  assign tbl_waddr = dec_id[CS_AW-1:0];

  assign idx_oor = (idx_r >= 8'(CHANNEL_SLOTS));

  always_comb begin
    pos_nxt     = pos_r;
    last_nxt    = last_r;
    pending_nxt = pending_r;
    ptr_nxt     = ptr_r;
    tv_nxt      = tv_r;
    if (cmd.byte_upd) begin
      last_nxt = ts_r;
      pos_nxt  = frame_done ? '0 : pos_inc[FB_AW-1:0];
      if (frame_done) begin
        pending_nxt = 1'b1;
      end
    end
    if (cmd.dec_start) begin
      ptr_nxt = FIRST_PAIR_HI;
    end else if (cmd.fs_re) begin
      ptr_nxt = ptr_r + FB_PW'(1);
    end
    if (tbl_wen) begin
      tv_nxt[tbl_waddr] = 1'b1;
    end
    if (cmd.dec_done) begin
      pending_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      last_r    <= '0;
      pending_r <= 1'b0;
      ptr_r     <= FIRST_PAIR_HI;
      tv_r      <= '0;
    end else begin
      pos_r     <= pos_nxt;
      last_r    <= last_nxt;
      pending_r <= pending_nxt;
      ptr_r     <= ptr_nxt;
      tv_r      <= tv_nxt;
    end
  end

  dsmrc_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (cmd.byte_upd),
    .waddr (pos_base),
    .wdata (data_r),
    .re    (cmd.fs_re),
    .raddr (ptr_r[FB_AW-1:0]),
    .rdata (fs_rdata)
  );

  dsmrc_ram #(
    .WIDTH (PULSE_W),
    .DEPTH (CHANNEL_SLOTS)
  ) u_table_ram (
    .clk   (clk),
    .we    (tbl_wen),
    .waddr (tbl_waddr),
    .wdata (dec_value),
    .re    (cmd.tbl_re),
    .raddr (idx_r[CS_AW-1:0]),
    .rdata (tbl_rdata)
  );

  // Result capture; a table entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (cmd.byte_upd) begin
      res_pulse_r <= '0;
      res_done_r  <= frame_done;
      res_oor_r   <= 1'b0;
    end else if (cmd.cap_read) begin
      res_done_r <= 1'b0;
      res_oor_r  <= idx_oor;
      if (idx_oor) begin
        res_pulse_r <= PULSE_DEFAULT;
      end else if (tv_r[idx_r[CS_AW-1:0]]) begin
        res_pulse_r <= tbl_rdata;
      end else begin
        res_pulse_r <= '0;
      end
    end
  end

  // Output register: a new result may load in the cycle the old one transfers.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pulse_r <= res_pulse_r;
      out_done_r  <= res_done_r;
      out_oor_r   <= res_oor_r;
    end
  end

  assign sts.pending    = pending_r;
  assign sts.more_pairs = (ptr_r < FB_PW'(FRAME_BYTES - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid              = out_valid_r;
  assign out_pulse_us           = out_pulse_r;
  assign out_frame_complete     = out_done_r;
  assign out_index_out_of_range = out_oor_r;

endmodule

/* sv/dsm_rc_frame_decoder_top.sv */
// Serial RC frame decoder.
// Input channel (in_valid / in_stall): each transfer is either a received
// byte with its microsecond arrival time (in_command = 0) or a channel
// read (in_command = 1). Output channel (out_valid / out_stall): exactly
// one result per input transfer, in order.
// The block works on one item at a time. A byte is stored in ST_BYTE;
// a read looks up the table in ST_TBL_RD and ST_TBL_WAIT, and when a
// complete frame is waiting it first fetches the first high byte and
// decodes the seven word pairs into the table. The pair walk is bound by
// the single read port of the frame RAM.
// in_stall is high from the cycle after a transfer until the result sits
// in the output register, which holds it while out_stall is high; the next
// item is taken while that result waits, and its own result waits until
// the register frees up.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once
// and must be made while no item is in flight; the block does not enforce it.
// Reset (rst_n low, synchronous) empties the output, restarts the frame
// position, clears the pending frame and the arrival time, restores the
// configuration defaults and makes every channel read as zero.
module dsm_rc_frame_decoder_top
  import dsmrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [7:0]            in_data_byte,
  input  logic [31:0]           in_timestamp_us,
  input  logic [7:0]            in_channel_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PULSE_W-1:0]    out_pulse_us,
  output logic                  out_frame_complete,
  output logic                  out_index_out_of_range,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  dsmrc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  dsmrc_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_data_byte           (in_data_byte),
    .in_timestamp_us        (in_timestamp_us),
    .in_channel_index       (in_channel_index),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_pulse_us           (out_pulse_us),
    .out_frame_complete     (out_frame_complete),
    .out_index_out_of_range (out_index_out_of_range)
  );

endmodule

/* tb/sv/dsm_rc_frame_decoder_checker.sv */
module dsm_rc_frame_decoder_checker
  import dsmrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_command,
  input  logic [7:0]            in_data_byte,
  input  logic [31:0]           in_timestamp_us,
  input  logic [7:0]            in_channel_index,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PULSE_W-1:0]    out_pulse_us,
  input  logic                  out_frame_complete,
  input  logic                  out_index_out_of_range,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    replies_owed
);

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_us;
    logic               frame_complete;
    logic               index_out_of_range;
  } decoder_reply_t;

  logic               res_mode;
  logic [4:0]         ch_limit;
  logic [15:0]        gap_limit;
  logic [7:0]         frame_bytes [FRAME_BYTES];
  int unsigned        byte_pos;
  logic [31:0]        last_arrival;
  logic               frame_ready;
  logic [PULSE_W-1:0] pulse_table [CHANNEL_SLOTS];
  decoder_reply_t     predicted_replies [$];

  initial begin
    mismatch_count = 0;
    replies_owed   = 0;
  end

  // Applies one input transfer to the local decoder state and returns its reply.
  task automatic predict_reply(input logic cmd, input logic [7:0] data,
                               input logic [31:0] ts, input logic [7:0] idx,
                               output decoder_reply_t reply);
    logic [31:0] gap;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [3:0]  id;
    logic [11:0] value;
    reply = '0;
    if (cmd == CMD_BYTE) begin
      gap = ts - last_arrival;
      last_arrival = ts;
      if (gap > {16'd0, gap_limit}) begin
        byte_pos = 0;
      end
      if (byte_pos >= FRAME_BYTES) begin
        byte_pos = 0;
      end
      frame_bytes[byte_pos] = data;
      byte_pos++;
      if (byte_pos >= FRAME_BYTES) begin
        frame_ready = 1'b1;
        byte_pos = 0;
        reply.frame_complete = 1'b1;
      end
    end else begin
      if (frame_ready) begin
        // Word pairs follow the two-byte header; a trailing odd byte is skipped.
        for (int i = 3; i < FRAME_BYTES; i += 2) begin
          hi = frame_bytes[i-1];
          lo = frame_bytes[i];
          if (res_mode) begin
            id    = hi[5:2];
            value = {2'b00, hi[1:0], lo} + 12'(PULSE_OFFSET);
          end else begin
            id    = hi[6:3];
            value = ({1'b0, hi[2:0], lo} >> 1) + 12'(PULSE_OFFSET);
          end
          if ({1'b0, id} < ch_limit && int'(id) < CHANNEL_SLOTS) begin
            pulse_table[id] = value[PULSE_W-1:0];
          end
        end
        frame_ready = 1'b0;
      end
      if (int'(idx) >= CHANNEL_SLOTS) begin
        reply.pulse_us           = PULSE_DEFAULT;
        reply.index_out_of_range = 1'b1;
      end else begin
        reply.pulse_us = pulse_table[idx];
      end
    end
  endtask

  always @(posedge clk) begin
    decoder_reply_t got;
    decoder_reply_t want;
    if (!rst_n) begin
      res_mode     = 1'b0;
      ch_limit     = LIMIT_RESET;
      gap_limit    = GAP_RESET;
      byte_pos     = 0;
      last_arrival = '0;
      frame_ready  = 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        frame_bytes[i] = '0;
      end
      for (int i = 0; i < CHANNEL_SLOTS; i++) begin
        pulse_table[i] = '0;
      end
      predicted_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RES_MODE:  res_mode  = cfg_wdata[0];
          CFG_CH_LIMIT:  ch_limit  = cfg_wdata[4:0];
          CFG_GAP_LIMIT: gap_limit = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_pulse_us, out_frame_complete, out_index_out_of_range};
        if (predicted_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: unexpected result pulse=%0d complete=%0b oor=%0b",
                     got.pulse_us, got.frame_complete, got.index_out_of_range);
          end
        end else begin
          want = predicted_replies.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected pulse=%0d complete=%0b oor=%0b, got pulse=%0d complete=%0b oor=%0b",
                       want.pulse_us, want.frame_complete, want.index_out_of_range,
                       got.pulse_us, got.frame_complete, got.index_out_of_range);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_reply(in_command, in_data_byte, in_timestamp_us, in_channel_index, want);
        predicted_replies.push_back(want);
      end
    end
    replies_owed = predicted_replies.size();
  end

endmodule

/* tb/sv/dsm_rc_frame_decoder_top_tb.sv */
module dsm_rc_frame_decoder_top_tb;
  import dsmrc_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 205;
  localparam int DIRECTED    = 25;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = CMD_BYTE;
  logic [7:0]            in_data_byte = '0;
  logic [31:0]           in_timestamp_us = '0;
  logic [7:0]            in_channel_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PULSE_W-1:0]    out_pulse_us;
  logic                  out_frame_complete;
  logic                  out_index_out_of_range;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RES_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int          mismatch_count;
  int          replies_owed;
  int          items_sent = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          hold_left = 0;
  logic        hold_spent = 1'b0;
  logic [31:0] air_time = '0;
  int unsigned cur_gap_limit = 5000;

  // Directed frame in the power-on setting (11-bit words): maximum pulse on
  // channel 0, minimum on 11, ids 12 and 15 above the limit, channel 0 rewritten.
  logic [7:0] directed_frame [FRAME_BYTES] = '{
    8'h00, 8'hFF, 8'h07, 8'hFF, 8'h58, 8'h00, 8'h60, 8'h55,
    8'hFF, 8'hFF, 8'h2A, 8'h34, 8'h83, 8'h80, 8'h0C, 8'h01
  };

  int phase_mode  [PHASES] = '{0, 1, 0, 1, 0, 1};
  int phase_limit [PHASES] = '{12, 16, 0, 10, 16, 31};
  int phase_gap   [PHASES] = '{5000, 65535, 0, 300, 1, 5000};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dsm_rc_frame_decoder_top u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_data_byte           (in_data_byte),
    .in_timestamp_us        (in_timestamp_us),
    .in_channel_index       (in_channel_index),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_pulse_us           (out_pulse_us),
    .out_frame_complete     (out_frame_complete),
    .out_index_out_of_range (out_index_out_of_range),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  dsm_rc_frame_decoder_checker u_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_data_byte           (in_data_byte),
    .in_timestamp_us        (in_timestamp_us),
    .in_channel_index       (in_channel_index),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_pulse_us           (out_pulse_us),
    .out_frame_complete     (out_frame_complete),
    .out_index_out_of_range (out_index_out_of_range),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .mismatch_count         (mismatch_count),
    .replies_owed           (replies_owed)
  );

  // Receiver side: random stalls, plus one long hold-off so the block backs up
  // and stalls its input while the sender keeps offering transfers.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_spent && items_sent >= 900) begin
      out_stall  <= 1'b1;
      hold_left  <= 400;
      hold_spent <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL dsm_rc_frame_decoder_top");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Leaves in_valid high on return; drain_block, or an idle cycle in the next call, lowers it.
  task automatic send_item(input logic cmd, input logic [7:0] data,
                           input logic [31:0] ts, input logic [7:0] idx);
    while (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_data_byte     <= data;
    in_timestamp_us  <= ts;
    in_channel_index <= idx;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] data, input logic [31:0] step);
    air_time = air_time + step;
    send_item(CMD_BYTE, data, air_time, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_read(input logic [7:0] idx);
    send_item(CMD_READ, 8'($urandom_range(0, 255)), $urandom(), idx);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_settings(input int mode, input int limit, input int gap);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RES_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_CH_LIMIT;
    cfg_wdata <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_index <= CFG_GAP_LIMIT;
    cfg_wdata <= CFG_DATA_W'(gap);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_gap_limit = gap;
  endtask

  task automatic pick_idle_mode();
    if (items_sent < 420) begin
      snd_idle_pct  = 11;
      rcv_stall_pct = 49;
    end else if (items_sent < 840) begin
      snd_idle_pct  = 49;
      rcv_stall_pct = 11;
    end else begin
      snd_idle_pct  = 0;
      rcv_stall_pct = 0;
    end
  endtask

  // A frame opens with an over-limit step in air_time to start it at position
  // zero; now and then one is broken by a second long gap partway through.
  task automatic send_frame();
    int cut;
    if ($urandom_range(0, 19) == 0) begin
      air_time = $urandom();
    end
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
    send_byte(pick_byte(), cur_gap_limit + 1 + $urandom_range(0, 2000));
    for (int b = 1; b < FRAME_BYTES; b++) begin
      if (b == cut) begin
        send_byte(pick_byte(), cur_gap_limit + 1 + $urandom_range(0, 2000));
      end else begin
        send_byte(pick_byte(), $urandom_range(0, cur_gap_limit));
      end
    end
    repeat ($urandom_range(1, 3)) begin
      send_read(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, CHANNEL_SLOTS + 1)));
    end
  endtask

  initial begin
    int action;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    pick_idle_mode();

    // Reads before any frame, in and beyond the table.
    send_read(8'd15);
    send_read(8'd255);
    // The first byte is timed from zero.
    send_byte(directed_frame[0], 32'd1000);
    for (int b = 1; b < FRAME_BYTES; b++) begin
      send_byte(directed_frame[b], 32'd100);
    end
    send_read(8'd0);
    send_read(8'd1);
    send_read(8'd11);
    send_read(8'd12);
    send_read(8'd16);
    // A gap exactly at the limit keeps the position; one more microsecond restarts it.
    send_byte(8'h5A, 32'd5000);
    send_byte(8'hA5, 32'd5001);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        write_settings(phase_mode[p], phase_limit[p], phase_gap[p]);
      end
      while (items_sent < DIRECTED + PHASE_ITEMS * (p + 1)) begin
        pick_idle_mode();
        action = $urandom_range(0, 99);
        if (action < 65) begin
          send_frame();
        end else if (action < 80) begin
          send_read(8'($urandom_range(0, 255)));
        end else begin
          send_item(CMD_BYTE, pick_byte(), $urandom(), 8'($urandom_range(0, 255)));
        end
      end
    end

    drain_block();
    if (mismatch_count == 0 && replies_owed == 0) begin
      $display("PASS dsm_rc_frame_decoder_top");
    end else begin
      $display("FAIL dsm_rc_frame_decoder_top");
    end
    $finish;
  end

endmodule
